// ----- design/biquad_iir_filter_unit_macros.svh -----
// ----------------------------------------------------------------------------
// biquad iir filter unit assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef BIQUAD_IIR_FILTER_UNIT_MACROS_SVH
`define BIQUAD_IIR_FILTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BIQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BIQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BIQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define BIQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- design/biq_pkg.sv -----
// ----------------------------------------------------------------------------
// biquad iir filter package
// widths, register indexes and reset gains shared by the filter files
// ----------------------------------------------------------------------------
package biq_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 32;
    localparam int DELAY_W    = 32;
    localparam int PROD_W     = COEF_W + SAMPLE_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int FRAC_SHIFT = 24;
    localparam int SHIFT_W    = ACC_W - FRAC_SHIFT;
    localparam int CFG_IDX_W  = 3;

    localparam int DEFAULT_CHANNELS = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FEED_GAIN_0 = 3'd0,
        REG_FEED_GAIN_1 = 3'd1,
        REG_FEED_GAIN_2 = 3'd2,
        REG_BACK_GAIN_1 = 3'd3,
        REG_BACK_GAIN_2 = 3'd4
    } biq_reg_idx_t;

    localparam logic signed [COEF_W-1:0] FEED_GAIN_0_RESET = 32'sd16777216;
    localparam logic signed [COEF_W-1:0] GAIN_ZERO_RESET   = 32'sd0;

endpackage

// ----- design/biq_if.sv -----
// ----------------------------------------------------------------------------
// biquad iir filter channels
// valid/ready request channels for samples in and filtered results out
// ----------------------------------------------------------------------------
interface biq_in_if import biq_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       chan_sel;
    logic signed [SAMPLE_W-1:0] in_sample;

    modport source (output valid, output chan_sel, output in_sample, input ready);
    modport sink (input valid, input chan_sel, input in_sample, output ready);
endinterface

interface biq_out_if import biq_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       out_chan;
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       clipped;

    modport source (output valid, output out_chan, output out_sample, output clipped,
                    input ready);
    modport sink (input valid, input out_chan, input out_sample, input clipped,
                  output ready);
endinterface

// ----- design/biquad_iir_filter_unit.sv -----
// ----------------------------------------------------------------------------
// biquad iir filter unit
// multi-channel second-order iir filter, transposed direct form ii
// ----------------------------------------------------------------------------
// samples: sink channel; a request carries chan_sel and a Q1.23 in_sample.
// results: source channel; a request carries out_chan, the saturated Q1.23
//   out_sample and clipped, one result per sample, in order.
// cfg: write port, cfg_index selects one of the five Q8.24 gains
//   (feed_gain_0..2, back_gain_1..2); write only while no sample is in work.
// one 32x24 multiplier and one 58-bit adder are shared by all five products
//   under a ten-state sequencer; a sample is accepted only from idle, so the
//   next sample waits until the current one has left the last step.
// samples.ready is high only while the sequencer is idle.
// a finished result sits in an output register; the next sample is accepted
//   while it waits, and the sequencer holds in its last step only when that
//   register is still full and results.ready is low.
// reset clears both delay values of every channel, sets feed_gain_0 to 1.0
//   and all other gains to zero (pass-through), and empties the output.
// a chan_sel not below CHANNELS reads zero delays and writes no state.
// ----------------------------------------------------------------------------
`include "biquad_iir_filter_unit_macros.svh"

module biquad_iir_filter_unit import biq_pkg::*; #(
    parameter int CHANNELS = DEFAULT_CHANNELS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_wdata,
    biq_in_if.sink               samples,
    biq_out_if.source            results
);

    localparam int STORE_DEPTH = (CHANNELS < 2) ? CHANNELS : 2;
    localparam int SEED_EXT_W  = ACC_W - DELAY_W - FRAC_SHIFT;

    localparam logic signed [SHIFT_W-1:0] SAMPLE_HI = SHIFT_W'(8388607);
    localparam logic signed [SHIFT_W-1:0] SAMPLE_LO = -SHIFT_W'(8388608);
    localparam logic signed [SHIFT_W-1:0] DELAY_HI  = SHIFT_W'(64'sd2147483647);
    localparam logic signed [SHIFT_W-1:0] DELAY_LO  = -SHIFT_W'(64'sd2147483648);
    localparam logic [FRAC_SHIFT-1:0]     ROUND_BIT = FRAC_SHIFT'(1) << (FRAC_SHIFT - 1);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_MUL0  = 10'b0000000010,
        ST_ADD0  = 10'b0000000100,
        ST_SATY  = 10'b0000001000,
        ST_MULB1 = 10'b0000010000,
        ST_SUB1  = 10'b0000100000,
        ST_SAT1  = 10'b0001000000,
        ST_MULB2 = 10'b0010000000,
        ST_SUB2  = 10'b0100000000,
        ST_SAT2  = 10'b1000000000
    } biq_state_t;

    biq_state_t state_reg, state_next;

    logic signed [COEF_W-1:0] feed_gain_0_reg, feed_gain_1_reg, feed_gain_2_reg;
    logic signed [COEF_W-1:0] back_gain_1_reg, back_gain_2_reg;

    logic signed [DELAY_W-1:0] first_delay_reg  [STORE_DEPTH];
    logic signed [DELAY_W-1:0] second_delay_reg [STORE_DEPTH];

    logic                       chan_reg;
    logic                       chan_ok_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [DELAY_W-1:0]  z1_reg, z2_reg;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic                       clip_reg;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;

    logic                       out_valid_reg;
    logic                       out_chan_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       out_clip_reg;

    logic signed [COEF_W-1:0]   mul_coef;
    logic signed [SAMPLE_W-1:0] mul_op;
    logic signed [ACC_W-1:0]    prod_ext;
    logic signed [SHIFT_W-1:0]  acc_shifted;
    logic signed [SAMPLE_W-1:0] y_sat;
    logic                       y_clip;
    logic signed [DELAY_W-1:0]  n_sat;
    logic signed [DELAY_W-1:0]  z1_sel, z2_sel;
    logic                       in_chan_ok;
    logic                       accept;
    logic                       out_free;
    logic                       finish;

    assign accept   = samples.valid && samples.ready;
    assign out_free = !out_valid_reg || results.ready;
    assign finish   = (state_reg == ST_SAT2) && out_free;

    assign samples.ready      = (state_reg == ST_IDLE);
    assign results.valid      = out_valid_reg;
    assign results.out_chan   = out_chan_reg;
    assign results.out_sample = out_sample_reg;
    assign results.clipped    = out_clip_reg;

    assign in_chan_ok = ({{31{1'b0}}, samples.chan_sel} < 32'(CHANNELS));

    // delay read for the incoming channel
    always_comb
    begin
        z1_sel = '0;
        z2_sel = '0;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            if (samples.chan_sel == 1'(i))
            begin
                z1_sel = first_delay_reg[i];
                z2_sel = second_delay_reg[i];
            end
        end
        if (!in_chan_ok)
        begin
            z1_sel = '0;
            z2_sel = '0;
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_MUL0:
            begin
                mul_coef = feed_gain_0_reg;
                mul_op   = x_reg;
            end
            ST_ADD0:
            begin
                mul_coef = feed_gain_1_reg;
                mul_op   = x_reg;
            end
            ST_MULB1:
            begin
                mul_coef = back_gain_1_reg;
                mul_op   = y_reg;
            end
            ST_SUB1:
            begin
                mul_coef = feed_gain_2_reg;
                mul_op   = x_reg;
            end
            ST_MULB2:
            begin
                mul_coef = back_gain_2_reg;
                mul_op   = y_reg;
            end
            default:
            begin
                mul_coef = feed_gain_0_reg;
                mul_op   = x_reg;
            end
        endcase
    end

    assign prod_next   = PROD_W'(mul_coef) * PROD_W'(mul_op);
    assign prod_ext    = ACC_W'(prod_reg);
    assign acc_shifted = acc_reg[ACC_W-1:FRAC_SHIFT];

    // round is folded into the accumulator seed; saturate here
    always_comb
    begin
        y_clip = 1'b0;
        if (acc_shifted > SAMPLE_HI)
        begin
            y_sat  = SAMPLE_HI[SAMPLE_W-1:0];
            y_clip = 1'b1;
        end
        else if (acc_shifted < SAMPLE_LO)
        begin
            y_sat  = SAMPLE_LO[SAMPLE_W-1:0];
            y_clip = 1'b1;
        end
        else
        begin
            y_sat = acc_shifted[SAMPLE_W-1:0];
        end

        if (acc_shifted > DELAY_HI)
        begin
            n_sat = DELAY_HI[DELAY_W-1:0];
        end
        else if (acc_shifted < DELAY_LO)
        begin
            n_sat = DELAY_LO[DELAY_W-1:0];
        end
        else
        begin
            n_sat = acc_shifted[DELAY_W-1:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MUL0;
                end
            end
            ST_MUL0:
            begin
                acc_next   = {{SEED_EXT_W{z1_reg[DELAY_W-1]}}, z1_reg, ROUND_BIT};
                state_next = ST_ADD0;
            end
            ST_ADD0:
            begin
                acc_next   = acc_reg + prod_ext;
                state_next = ST_SATY;
            end
            ST_SATY:
            begin
                acc_next   = {{SEED_EXT_W{z2_reg[DELAY_W-1]}}, z2_reg, ROUND_BIT} + prod_ext;
                state_next = ST_MULB1;
            end
            ST_MULB1:
            begin
                state_next = ST_SUB1;
            end
            ST_SUB1:
            begin
                acc_next   = acc_reg - prod_ext;
                state_next = ST_SAT1;
            end
            ST_SAT1:
            begin
                acc_next   = ACC_W'(ROUND_BIT) + prod_ext;
                state_next = ST_MULB2;
            end
            ST_MULB2:
            begin
                state_next = ST_SUB2;
            end
            ST_SUB2:
            begin
                acc_next   = acc_reg - prod_ext;
                state_next = ST_SAT2;
            end
            ST_SAT2:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // gain registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feed_gain_0_reg <= FEED_GAIN_0_RESET;
            feed_gain_1_reg <= GAIN_ZERO_RESET;
            feed_gain_2_reg <= GAIN_ZERO_RESET;
            back_gain_1_reg <= GAIN_ZERO_RESET;
            back_gain_2_reg <= GAIN_ZERO_RESET;
        end
        else if (cfg_we)
        begin
            case (biq_reg_idx_t'(cfg_index))
                REG_FEED_GAIN_0: feed_gain_0_reg <= cfg_wdata;
                REG_FEED_GAIN_1: feed_gain_1_reg <= cfg_wdata;
                REG_FEED_GAIN_2: feed_gain_2_reg <= cfg_wdata;
                REG_BACK_GAIN_1: back_gain_1_reg <= cfg_wdata;
                REG_BACK_GAIN_2: back_gain_2_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // per-channel delay state
    for (genvar g = 0; g < STORE_DEPTH; g++)
    begin : g_delay
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                first_delay_reg[g]  <= '0;
                second_delay_reg[g] <= '0;
            end
            else if (chan_ok_reg && (chan_reg == 1'(g)))
            begin
                if (state_reg == ST_SAT1)
                begin
                    first_delay_reg[g] <= n_sat;
                end
                if (finish)
                begin
                    second_delay_reg[g] <= n_sat;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (accept)
        begin
            chan_reg    <= samples.chan_sel;
            chan_ok_reg <= in_chan_ok;
            x_reg       <= samples.in_sample;
            z1_reg      <= z1_sel;
            z2_reg      <= z2_sel;
        end
        if (state_reg == ST_SATY)
        begin
            y_reg    <= y_sat;
            clip_reg <= y_clip;
        end
        if (finish)
        begin
            out_chan_reg   <= chan_reg;
            out_sample_reg <= y_reg;
            out_clip_reg   <= clip_reg;
        end
    end

    `BIQ_ASSERT_NEXT(a_accept_starts, clk, rst_n, accept,
        (state_reg == ST_MUL0) && !samples.ready, "sample accepted but sequencer not started")
    `BIQ_ASSERT_NEXT(a_finish_delivers, clk, rst_n, finish,
        results.valid && (results.out_chan == $past(chan_reg)), "result lost or wrong channel")
    `BIQ_ASSERT_NOW(a_clip_at_bound, clk, rst_n, results.valid && results.clipped,
        (results.out_sample == SAMPLE_HI[SAMPLE_W-1:0]) ||
        (results.out_sample == SAMPLE_LO[SAMPLE_W-1:0]), "clipped result not at a bound")

endmodule
